// ----- hdl/dfbc_pkg.sv -----
package dfbc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_START   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ADDRESS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MODE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COLUMNS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ROWS    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STOP    = 3'd5;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam logic [7:0] TAG_WIDTH  = 8'hd0;
  localparam logic [7:0] TAG_HEIGHT = 8'hd1;
  localparam logic [7:0] ESC_MARK   = 8'hfe;
  localparam logic [7:0] ESC_ALT    = 8'hff;
  localparam logic [7:0] ESC_LO     = 8'h00;
  localparam logic [7:0] ESC_HI     = 8'h01;
  localparam logic [7:0] TRAIL_BYTE = 8'h00;

  localparam logic [7:0] RST_START   = 8'hff;
  localparam logic [7:0] RST_ADDRESS = 8'h00;
  localparam logic [7:0] RST_MODE    = 8'ha2;
  localparam logic [7:0] RST_COLUMNS = 8'h70;
  localparam logic [7:0] RST_ROWS    = 8'h10;
  localparam logic [7:0] RST_STOP    = 8'hff;

  typedef enum logic [3:0] {
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_HDR3,
    PH_HDR4,
    PH_HDR5,
    PH_HDR6,
    PH_DATA,
    PH_SUM,
    PH_ESC,
    PH_STOP,
    PH_ZERO
  } phase_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] display_address;
    logic [7:0] mode_byte;
    logic [7:0] column_count;
    logic [7:0] row_count;
    logic [7:0] stop_byte;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       frame_end;
  } beat_t;

endpackage

// ----- hdl/dfbc_cfg_regs.sv -----
module dfbc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dfbc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                   cfg_data,
  output dfbc_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte      <= dfbc_pkg::RST_START;
      cfg.display_address <= dfbc_pkg::RST_ADDRESS;
      cfg.mode_byte       <= dfbc_pkg::RST_MODE;
      cfg.column_count    <= dfbc_pkg::RST_COLUMNS;
      cfg.row_count       <= dfbc_pkg::RST_ROWS;
      cfg.stop_byte       <= dfbc_pkg::RST_STOP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfbc_pkg::REG_START:   cfg.start_byte      <= cfg_data;
        dfbc_pkg::REG_ADDRESS: cfg.display_address <= cfg_data;
        dfbc_pkg::REG_MODE:    cfg.mode_byte       <= cfg_data;
        dfbc_pkg::REG_COLUMNS: cfg.column_count    <= cfg_data;
        dfbc_pkg::REG_ROWS:    cfg.row_count       <= cfg_data;
        dfbc_pkg::REG_STOP:    cfg.stop_byte       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/dfbc_seq.sv -----
module dfbc_seq (
  input  logic                clk,
  input  logic                rst,
  input  dfbc_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [7:0]          payload_byte,
  output logic                beat_valid,
  input  logic                beat_ready,
  output dfbc_pkg::beat_t     beat
);

  logic             busy;
  logic             func_q;
  logic [7:0]       payload_q;
  dfbc_pkg::phase_t phase;
  dfbc_pkg::phase_t phase_next;
  dfbc_pkg::phase_t phase_first;
  logic             frame_open;
  logic             frame_open_next;
  logic [7:0]       running_sum;
  logic [7:0]       running_sum_next;
  logic             advance;
  logic             accept;
  logic             summed;
  logic             last_beat;

  assign advance    = busy && beat_ready;
  assign last_beat  = (phase == dfbc_pkg::PH_DATA) || (phase == dfbc_pkg::PH_ZERO);
  assign in_ready   = !busy || (advance && last_beat);
  assign accept     = in_valid && in_ready;
  assign beat_valid = busy;

  always_comb begin
    beat.last      = last_beat;
    beat.frame_end = (phase == dfbc_pkg::PH_ZERO);
    summed         = 1'b1;
    unique case (phase)
      dfbc_pkg::PH_HDR0: begin
        beat.data = cfg.start_byte;
        summed    = 1'b0;
      end
      dfbc_pkg::PH_HDR1: beat.data = cfg.display_address;
      dfbc_pkg::PH_HDR2: beat.data = cfg.mode_byte;
      dfbc_pkg::PH_HDR3: beat.data = dfbc_pkg::TAG_WIDTH;
      dfbc_pkg::PH_HDR4: beat.data = cfg.column_count;
      dfbc_pkg::PH_HDR5: beat.data = dfbc_pkg::TAG_HEIGHT;
      dfbc_pkg::PH_HDR6: beat.data = cfg.row_count;
      dfbc_pkg::PH_DATA: beat.data = payload_q;
      dfbc_pkg::PH_SUM: begin
        summed    = 1'b0;
        beat.data = (running_sum == dfbc_pkg::ESC_MARK || running_sum == dfbc_pkg::ESC_ALT)
                    ? dfbc_pkg::ESC_MARK : running_sum;
      end
      dfbc_pkg::PH_ESC: begin
        summed    = 1'b0;
        beat.data = (running_sum == dfbc_pkg::ESC_ALT) ? dfbc_pkg::ESC_HI : dfbc_pkg::ESC_LO;
      end
      dfbc_pkg::PH_STOP: begin
        summed    = 1'b0;
        beat.data = cfg.stop_byte;
      end
      default: begin
        summed    = 1'b0;
        beat.data = dfbc_pkg::TRAIL_BYTE;
      end
    endcase
  end

  always_comb begin
    unique case (phase)
      dfbc_pkg::PH_HDR0: phase_next = dfbc_pkg::PH_HDR1;
      dfbc_pkg::PH_HDR1: phase_next = dfbc_pkg::PH_HDR2;
      dfbc_pkg::PH_HDR2: phase_next = dfbc_pkg::PH_HDR3;
      dfbc_pkg::PH_HDR3: phase_next = dfbc_pkg::PH_HDR4;
      dfbc_pkg::PH_HDR4: phase_next = dfbc_pkg::PH_HDR5;
      dfbc_pkg::PH_HDR5: phase_next = dfbc_pkg::PH_HDR6;
      dfbc_pkg::PH_HDR6: phase_next = (func_q == dfbc_pkg::FUNC_FINISH)
                                      ? dfbc_pkg::PH_SUM : dfbc_pkg::PH_DATA;
      dfbc_pkg::PH_SUM:  phase_next = (running_sum == dfbc_pkg::ESC_MARK ||
                                       running_sum == dfbc_pkg::ESC_ALT)
                                      ? dfbc_pkg::PH_ESC : dfbc_pkg::PH_STOP;
      dfbc_pkg::PH_ESC:  phase_next = dfbc_pkg::PH_STOP;
      dfbc_pkg::PH_STOP: phase_next = dfbc_pkg::PH_ZERO;
      default:           phase_next = dfbc_pkg::PH_HDR0;
    endcase
  end

  always_comb begin
    frame_open_next  = frame_open;
    running_sum_next = running_sum;
    if (advance) begin
      if (phase == dfbc_pkg::PH_HDR6) begin
        frame_open_next = 1'b1;
      end
      if (phase == dfbc_pkg::PH_ZERO) begin
        frame_open_next  = 1'b0;
        running_sum_next = '0;
      end else if (summed) begin
        running_sum_next = running_sum + beat.data;
      end
    end
  end

  // entry phase follows the frame state left by the beat leaving this cycle
  always_comb begin
    if (!frame_open_next) begin
      phase_first = dfbc_pkg::PH_HDR0;
    end else if (func == dfbc_pkg::FUNC_FINISH) begin
      phase_first = dfbc_pkg::PH_SUM;
    end else begin
      phase_first = dfbc_pkg::PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      phase       <= dfbc_pkg::PH_HDR0;
      frame_open  <= 1'b0;
      running_sum <= '0;
    end else begin
      frame_open  <= frame_open_next;
      running_sum <= running_sum_next;
      if (accept) begin
        busy  <= 1'b1;
        phase <= phase_first;
      end else if (advance) begin
        if (last_beat) begin
          busy <= 1'b0;
        end else begin
          phase <= phase_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= func;
      payload_q <= payload_byte;
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    advance && phase == dfbc_pkg::PH_ZERO |=> !frame_open && running_sum == '0)
    else $error("frame state not cleared after trailing byte");

  a_header_opens: assert property (@(posedge clk) disable iff (rst)
    advance && phase == dfbc_pkg::PH_HDR6 |=> frame_open)
    else $error("frame not open after header");

  a_data_in_frame: assert property (@(posedge clk) disable iff (rst)
    busy && (phase == dfbc_pkg::PH_DATA || phase == dfbc_pkg::PH_SUM) |-> frame_open)
    else $error("payload or checksum outside an open frame");

  a_esc_only_high: assert property (@(posedge clk) disable iff (rst)
    busy && phase == dfbc_pkg::PH_ESC |->
      running_sum == dfbc_pkg::ESC_MARK || running_sum == dfbc_pkg::ESC_ALT)
    else $error("escape beat for an unescaped checksum");

endmodule

// ----- hdl/dfbc_out_stage.sv -----
module dfbc_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            beat_valid,
  output logic            beat_ready,
  input  dfbc_pkg::beat_t beat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            frame_end
);

  dfbc_pkg::beat_t held;

  assign beat_ready = !out_valid || out_ready;
  assign out_byte   = held.data;
  assign run_last   = held.last;
  assign frame_end  = held.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat_ready) begin
      out_valid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_ready && beat_valid) begin
      held <= beat;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_last)
    else $error("frame end beat not marked last");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(held))
    else $error("stalled beat changed");

  a_end_trail: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> out_byte == dfbc_pkg::TRAIL_BYTE)
    else $error("frame end on a non-zero byte");

endmodule

// ----- hdl/display_frame_builder_checksum_unit.sv -----
// Path: an item's first byte passes the sequencer phase register, then the output register.
// Throughput: one frame byte per cycle while out_ready holds, through the single output byte
// register; an append into an open frame sends its data byte, a finish the checksum, escape
// byte (when needed), stop and trailing bytes, each led by the header when no frame is open.
// Reset (rst, synchronous): registers to defaults, no frame open, checksum zero, no beat held.
module display_frame_builder_checksum_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dfbc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [7:0]                   payload_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic                         run_last,
  output logic                         frame_end
);

  dfbc_pkg::cfg_t  cfg;
  dfbc_pkg::beat_t beat;
  logic            beat_valid;
  logic            beat_ready;

  dfbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfbc_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .payload_byte (payload_byte),
    .beat_valid   (beat_valid),
    .beat_ready   (beat_ready),
    .beat         (beat)
  );

  dfbc_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_end  (frame_end)
  );

endmodule
